@@ src/psc_pkg.sv @@
package psc_pkg;

  localparam int RAW_W       = 24;
  localparam int CAL_W       = 16;
  localparam int NUM_CAL     = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int TEMP_W      = 18;
  localparam int PRES_W      = 24;
  localparam int SUM_W       = 64;
  localparam int MAG_W       = 64;
  localparam int YMAG_W      = 47;
  localparam int DIV_STEPS   = 47;
  localparam int CNT_W       = 6;
  localparam int M1_W        = 57;
  localparam int VMAG_W      = 48;
  localparam int ACC_W       = 105;
  localparam int P_W         = 52;
  localparam int S_W         = 51;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [16:0] TEMP_LIMIT = 17'd100000;
  localparam logic signed [PRES_W-1:0] PRES_MAX = 24'sh7FFFFF;
  localparam logic signed [PRES_W-1:0] PRES_MIN = 24'sh800000;

  typedef logic [NUM_CAL-1:0][CAL_W-1:0] psc_cal_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } psc_in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_centi;
    logic signed [PRES_W-1:0] pressure_pascal;
    logic                     divide_error;
  } psc_out_t;

  typedef struct packed {
    logic signed [13:0] c0;
    logic signed [13:0] c1;
    logic signed [9:0]  c2;
    logic signed [9:0]  c3;
    logic signed [9:0]  c4;
    logic signed [9:0]  c5;
    logic signed [9:0]  c6;
    logic signed [9:0]  a0;
    logic signed [9:0]  a1;
    logic signed [9:0]  a2;
  } psc_coef_t;

  // One classified item waiting for the divider.
  typedef struct packed {
    logic signed [SUM_W-1:0]  top;
    logic signed [SUM_W-1:0]  bot;
    logic signed [TEMP_W-1:0] centi;
    logic                     err;
  } psc_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIV,
    BK_MULA,
    BK_MULB,
    BK_SUM,
    BK_SCALE,
    BK_DONE
  } psc_back_state_t;

  function automatic psc_coef_t psc_unpack(input psc_cal_t w);
    psc_coef_t c;
    c.c0 = w[0][15:2];
    c.c1 = {w[0][1:0], w[1][15:4]};
    c.c2 = {w[1][3:0], w[2][15:10]};
    c.c3 = w[2][9:0];
    c.c4 = w[3][15:6];
    c.c5 = {w[3][5:0], w[4][15:12]};
    c.c6 = w[4][11:2];
    c.a0 = {w[4][1:0], w[5][15:8]};
    c.a1 = {w[5][7:0], w[6][15:14]};
    c.a2 = w[6][13:4];
    return c;
  endfunction

endpackage

@@ src/psc_front.sv @@
module psc_front import psc_pkg::*; #(
  parameter int RAW_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  psc_in_t    in_data,
  input  psc_coef_t  coef,
  input  logic       q_full,
  output logic       q_push,
  output psc_entry_t q_entry
);

  localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((64'd1 << RAW_BITS) - 64'd1);

  logic [6:0] vld_r, vld_nxt;
  logic       advance;

  logic [RAW_W-1:0]      d1, d2;
  logic signed [RAW_W:0] d2s;

  logic [RAW_W-1:0]      s1_d1_r, s2_d1_r;
  logic [2*RAW_W-1:0]    s1_d2sq_r;
  logic signed [34:0]    s1_c3d2_r, s1_c5d2_r, s1_a1d2_r;
  logic signed [34:0]    s2_c3d2_r, s2_c5d2_r, s2_a1d2_r;
  logic signed [58:0]    s2_c4sq_r, s2_c6sq_r, s2_a2sq_r;
  logic signed [SUM_W-1:0] s3_top_r, s3_bot_r, s3_tn_r;
  logic signed [SUM_W-1:0] s4_top_r, s4_bot_r, s5_top_r, s5_bot_r, s6_top_r, s6_bot_r;
  logic [SUM_W-1:0]      s4_tm_r;
  logic                  s4_tneg_r, s5_tneg_r, s6_tneg_r;
  logic                  s5_bzero_r, s6_bzero_r;
  logic [18:0]           s5_xs_r;
  logic [38:0]           s6_prod_r;
  psc_entry_t            s7_r;

  logic signed [SUM_W-1:0] top_c, bot_c, tn_c;
  logic [70:0]             x100_c;
  logic [18:0]             cm_c;
  logic [16:0]             cmc_c;

  assign d1      = in_data.raw_pressure & RAW_MASK;
  assign d2      = in_data.raw_temperature & RAW_MASK;
  assign d2s     = $signed({1'b0, d2});
  assign advance = !vld_r[6] || !q_full;
  assign in_ready = advance;
  assign q_push  = vld_r[6] && !q_full;
  assign q_entry = s7_r;

  always_comb begin
    vld_nxt = vld_r;
    if (advance) begin
      vld_nxt = {vld_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    top_c = ($signed({40'd0, s2_d1_r}) <<< 34) + (SUM_W'(coef.c0) <<< 44)
          + (SUM_W'(s2_c3d2_r) <<< 25) + SUM_W'(s2_c4sq_r);
    bot_c = (SUM_W'(coef.c1) <<< 46) + (SUM_W'(s2_c5d2_r) <<< 26)
          + (SUM_W'(s2_c6sq_r) <<< 1);
    tn_c  = (SUM_W'(coef.a0) <<< 50) + ((SUM_W'(s2_a1d2_r) * 64'sd6) <<< 25)
          + (SUM_W'(s2_a2sq_r) * 64'sd6);
    // Round half away from zero: (100*|tn| + den/2) / (3 * 2^50).
    x100_c = 71'(s4_tm_r) * 71'd100 + (71'd3 << 49);
    cm_c   = s6_prod_r[38:20];
    cmc_c  = (cm_c > 19'(TEMP_LIMIT)) ? TEMP_LIMIT : cm_c[16:0];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_d1_r   <= d1;
      s1_d2sq_r <= 48'(d2) * 48'(d2);
      s1_c3d2_r <= 35'(coef.c3) * 35'(d2s);
      s1_c5d2_r <= 35'(coef.c5) * 35'(d2s);
      s1_a1d2_r <= 35'(coef.a1) * 35'(d2s);

      s2_d1_r   <= s1_d1_r;
      s2_c3d2_r <= s1_c3d2_r;
      s2_c5d2_r <= s1_c5d2_r;
      s2_a1d2_r <= s1_a1d2_r;
      s2_c4sq_r <= 59'(coef.c4) * 59'($signed({1'b0, s1_d2sq_r}));
      s2_c6sq_r <= 59'(coef.c6) * 59'($signed({1'b0, s1_d2sq_r}));
      s2_a2sq_r <= 59'(coef.a2) * 59'($signed({1'b0, s1_d2sq_r}));

      s3_top_r <= top_c;
      s3_bot_r <= bot_c;
      s3_tn_r  <= tn_c;

      s4_top_r  <= s3_top_r;
      s4_bot_r  <= s3_bot_r;
      s4_tm_r   <= s3_tn_r[SUM_W-1] ? SUM_W'(-s3_tn_r) : SUM_W'(s3_tn_r);
      s4_tneg_r <= s3_tn_r[SUM_W-1];

      s5_top_r   <= s4_top_r;
      s5_bot_r   <= s4_bot_r;
      s5_bzero_r <= (s4_bot_r == '0);
      s5_tneg_r  <= s4_tneg_r;
      s5_xs_r    <= x100_c[68:50];

      // Divide by three through the reciprocal, exact for 19-bit values.
      s6_top_r   <= s5_top_r;
      s6_bot_r   <= s5_bot_r;
      s6_bzero_r <= s5_bzero_r;
      s6_tneg_r  <= s5_tneg_r;
      s6_prod_r  <= 39'(s5_xs_r) * 39'd349526;

      s7_r.top   <= s6_top_r;
      s7_r.bot   <= s6_bot_r;
      s7_r.err   <= s6_bzero_r;
      s7_r.centi <= s6_tneg_r ? -$signed({1'b0, cmc_c}) : $signed({1'b0, cmc_c});
    end
  end

endmodule

@@ src/psc_queue.sv @@
module psc_queue import psc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  psc_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output psc_entry_t pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  psc_entry_t       mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/psc_back.sv @@
module psc_back import psc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  psc_entry_t q_entry,
  output logic       q_pop,
  input  psc_coef_t  coef,
  output logic       out_valid,
  input  logic       out_ready,
  output psc_out_t   out_data
);

  psc_back_state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  psc_out_t        out_data_r, out_data_nxt;

  logic [MAG_W-1:0]        tm_r, tm_nxt, bm_r, bm_nxt, r_r, r_nxt;
  logic                    ysign_r, ysign_nxt, err_r, err_nxt;
  logic signed [TEMP_W-1:0] centi_r, centi_nxt;
  logic [YMAG_W-1:0]       nb_r, nb_nxt, ymag_r, ymag_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [M1_W-1:0]         m1_r, m1_nxt;
  logic [VMAG_W-1:0]       vmag_r, vmag_nxt;
  logic                    tneg_r, tneg_nxt;
  logic signed [48:0]      yq_r, yq_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [1:0]              step_r, step_nxt;
  logic signed [P_W-1:0]   p_r, p_nxt;
  logic signed [S_W-1:0]   s_r, s_nxt;
  logic                    phi_r, phi_nxt, plo_r, plo_nxt;

  logic [MAG_W:0]          rs_c;
  logic                    ge_c, yneg_c, vneg_c, c2neg_c;
  logic signed [48:0]      yq_c;
  logic signed [49:0]      v_c;
  logic [9:0]              c2mag_c;
  logic [28:0]             mul_a_c;
  logic [23:0]             mul_b_c;
  logic [52:0]             pp_c;
  logic [ACC_W-1:0]        pp_sh_c;
  logic [50:0]             tmag_c;
  logic signed [P_W-1:0]   term_c;
  logic signed [26:0]      f_c;
  logic signed [27:0]      g_c;
  logic signed [PRES_W-1:0] pa_c;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    tm_nxt = tm_r;   bm_nxt = bm_r;   r_nxt = r_r;
    ysign_nxt = ysign_r; err_nxt = err_r; centi_nxt = centi_r;
    nb_nxt = nb_r;   ymag_nxt = ymag_r; cnt_nxt = cnt_r;
    m1_nxt = m1_r;   vmag_nxt = vmag_r; tneg_nxt = tneg_r; yq_nxt = yq_r;
    acc_nxt = acc_r; step_nxt = step_r; p_nxt = p_r; s_nxt = s_r;
    phi_nxt = phi_r; plo_nxt = plo_r;

    rs_c    = {r_r, nb_r[YMAG_W-1]};
    ge_c    = (rs_c >= {1'b0, bm_r});
    yneg_c  = ysign_r && (ymag_r != '0);
    yq_c    = yneg_c ? -$signed({2'b0, ymag_r}) : $signed({2'b0, ymag_r});
    v_c     = 50'(yq_c) - 50'sd16777216;
    vneg_c  = v_c[49];
    c2neg_c = coef.c2[9];
    c2mag_c = c2neg_c ? 10'(-coef.c2) : 10'(coef.c2);
    mul_a_c = step_r[1] ? {1'b0, m1_r[M1_W-1:29]} : m1_r[28:0];
    mul_b_c = step_r[0] ? vmag_r[47:24] : vmag_r[23:0];
    pp_c    = 53'(mul_a_c) * 53'(mul_b_c);
    case (step_r)
      2'd0:    pp_sh_c = ACC_W'(pp_c);
      2'd1:    pp_sh_c = ACC_W'(pp_c) << 24;
      2'd2:    pp_sh_c = ACC_W'(pp_c) << 29;
      default: pp_sh_c = ACC_W'(pp_c) << 53;
    endcase
    // The correction saturates at 2^50 once the product reaches 2^89.
    tmag_c  = (acc_r[ACC_W-1:89] != '0) ? (51'd1 << 50) : acc_r[89:39];
    term_c  = tneg_r ? -$signed({1'b0, tmag_c}) : $signed({1'b0, tmag_c});
    f_c     = $signed(s_r[S_W-1:24]);
    g_c     = 28'(f_c) - 28'sd75000;
    if (phi_r) begin
      pa_c = PRES_MAX;
    end else if (plo_r) begin
      pa_c = PRES_MIN;
    end else if (g_c > 28'sd8388607) begin
      pa_c = PRES_MAX;
    end else if (g_c < -28'sd8388608) begin
      pa_c = PRES_MIN;
    end else begin
      pa_c = PRES_W'(g_c);
    end

    unique case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          tm_nxt    = q_entry.top[SUM_W-1] ? MAG_W'(-q_entry.top) : MAG_W'(q_entry.top);
          bm_nxt    = q_entry.bot[SUM_W-1] ? MAG_W'(-q_entry.bot) : MAG_W'(q_entry.bot);
          ysign_nxt = q_entry.top[SUM_W-1] ^ q_entry.bot[SUM_W-1];
          centi_nxt = q_entry.centi;
          err_nxt   = q_entry.err;
          state_nxt = q_entry.err ? BK_DONE : BK_LOAD;
        end
      end
      BK_LOAD: begin
        // A quotient of 2^23 or more clamps to the largest magnitude.
        if ({23'd0, tm_r} >= {bm_r, 23'd0}) begin
          ymag_nxt  = '1;
          state_nxt = BK_MULA;
        end else begin
          r_nxt     = tm_r >> 23;
          nb_nxt    = {tm_r[22:0], 24'd0};
          cnt_nxt   = CNT_W'(DIV_STEPS);
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        r_nxt    = ge_c ? MAG_W'(rs_c - {1'b0, bm_r}) : MAG_W'(rs_c);
        ymag_nxt = {ymag_r[YMAG_W-2:0], ge_c};
        nb_nxt   = nb_r << 1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = BK_MULA;
        end
      end
      BK_MULA: begin
        yq_nxt    = yq_c;
        vmag_nxt  = vneg_c ? VMAG_W'(-v_c) : VMAG_W'(v_c);
        m1_nxt    = M1_W'(c2mag_c) * M1_W'(ymag_r);
        tneg_nxt  = c2neg_c ^ yneg_c ^ vneg_c;
        acc_nxt   = '0;
        step_nxt  = '0;
        state_nxt = BK_MULB;
      end
      BK_MULB: begin
        acc_nxt  = acc_r + pp_sh_c;
        step_nxt = step_r + 1'b1;
        if (step_r == 2'd3) begin
          state_nxt = BK_SUM;
        end
      end
      BK_SUM: begin
        p_nxt     = P_W'(yq_r) + term_c;
        state_nxt = BK_SCALE;
      end
      BK_SCALE: begin
        phi_nxt   = (p_r >= 52'sd536870912);
        plo_nxt   = (p_r <= -52'sd536870912);
        s_nxt     = S_W'($signed(p_r[29:0])) * 51'sd750000 + 51'sd8388608;
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_data_nxt.temp_centi      = '0;
            out_data_nxt.pressure_pascal = '0;
            out_data_nxt.divide_error    = 1'b1;
          end else begin
            out_data_nxt.temp_centi      = centi_r;
            out_data_nxt.pressure_pascal = pa_c;
            out_data_nxt.divide_error    = 1'b0;
          end
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    tm_r <= tm_nxt;   bm_r <= bm_nxt;   r_r <= r_nxt;
    ysign_r <= ysign_nxt; err_r <= err_nxt; centi_r <= centi_nxt;
    nb_r <= nb_nxt;   ymag_r <= ymag_nxt; cnt_r <= cnt_nxt;
    m1_r <= m1_nxt;   vmag_r <= vmag_nxt; tneg_r <= tneg_nxt; yq_r <= yq_nxt;
    acc_r <= acc_nxt; step_r <= step_nxt; p_r <= p_nxt; s_r <= s_nxt;
    phi_r <= phi_nxt; plo_r <= plo_nxt;
  end

endmodule

@@ src/pressure_sensor_compensation.sv @@
// Compensates one raw pressure/temperature pair per transfer, using seven
// 16-bit calibration words written on the cfg port. The user must write them
// only while the block is idle; the block itself does not enforce this.
// A seven-stage front pipeline forms the numerator, denominator and the
// rounded temperature and takes a new pair every cycle while its two-entry
// queue has room. The back end then works on one item at a time: the
// one-bit-per-cycle restoring divider forms the pressure quotient, then a
// 29x24 multiplier (four passes) and the scaling steps finish it. A
// quotient that clamps skips the divider, and a zero denominator goes
// straight to an error result. A finished result waits in the output
// register while the next item is computed; that next result is held
// until the output register is free.
module pressure_sensor_compensation import psc_pkg::*; #(
  parameter int RAW_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  psc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output psc_out_t             out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]     cfg_wdata
);

  psc_cal_t   cal_r;
  psc_coef_t  coef;
  logic       q_push, q_full, q_pop, q_not_empty;
  psc_entry_t q_in, q_out;

  assign coef = psc_unpack(cal_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_CAL))) begin
      cal_r[cfg_index] <= cfg_wdata;
    end
  end

  psc_front #(
    .RAW_BITS(RAW_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .coef    (coef),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  psc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (q_out)
  );

  psc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_entry    (q_out),
    .q_pop      (q_pop),
    .coef       (coef),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
